// ===== rtl/qoer_pkg.sv =====
// ---------------------------------------------------------------------------
// qoer_pkg
// Types, constants and datapath steps of the orientation error rate pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package qoer_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int VEC_W        = 34;
  localparam int ANG_W        = 20;
  localparam int SQ_W         = 58;
  localparam int ROOT_W       = 29;
  localparam int DIV_REM_W    = 44;
  localparam int DIV_STEPS    = 19;
  localparam int NORM_W       = 25;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [ANG_W-1:0] TRIG_MAX    = 20'sd16384;
  localparam logic signed [15:0]      PITCH_COS   = 16'sd11590;
  localparam logic signed [15:0]      PITCH_SIN   = 16'sd11581;
  localparam logic signed [43:0]      Q42_MAX     = 44'sd16384;
  localparam logic signed [43:0]      Q42_HALF    = 44'sd134217728;
  localparam logic signed [33:0]      ONE_Q28     = 34'sd268435456;
  localparam logic [SQ_W-1:0]         ONE_Q56     = 58'd1 << 56;
  localparam logic signed [35:0]      RATE_HALF   = 36'sd32768;
  localparam logic signed [19:0]      RATE_MAX    = 20'sd32767;
  localparam logic signed [19:0]      RATE_MIN    = -20'sd32768;

  typedef enum logic [1:0] {
    CFG_GAIN_X = 2'd0,
    CFG_GAIN_Y = 2'd1,
    CFG_GAIN_Z = 2'd2
  } cfg_idx_e;

  typedef logic signed [15:0] q14_t;
  typedef q14_t quat_t [4];

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] a;
    logic                    neg;
  } rot_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_STEPS-1:0] quo;
    logic                 neg;
  } div_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(int unsigned i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:       v = 20'sd51472;
      1:       v = 20'sd30386;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic vec_t vec_pre(logic signed [VEC_W-1:0] x, logic signed [VEC_W-1:0] y);
    vec_t r;
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x[VEC_W-1]) begin
      r.x = -x;
      r.y = -y;
      r.z = y[VEC_W-1] ? -ANG_PI : ANG_PI;
    end
    return r;
  endfunction

  function automatic vec_t vec_step(vec_t a, int unsigned i);
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    vec_t r;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (!a.y[VEC_W-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_lut(i);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_lut(i);
    end
    return r;
  endfunction

  function automatic rot_t rot_pre(logic signed [ANG_W-1:0] a);
    rot_t r;
    r.x   = CORDIC_GAIN;
    r.y   = '0;
    r.a   = a;
    r.neg = 1'b0;
    if (a > ANG_HALF_PI) begin
      r.a   = a - ANG_PI;
      r.neg = 1'b1;
    end else if (a < -ANG_HALF_PI) begin
      r.a   = a + ANG_PI;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  function automatic rot_t rot_step(rot_t a, int unsigned i);
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    rot_t r;
    dx = a.y >>> i;
    dy = a.x >>> i;
    r.neg = a.neg;
    if (!a.a[ANG_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.a = a.a - atan_lut(i);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.a = a.a + atan_lut(i);
    end
    return r;
  endfunction

  function automatic q14_t trig_q14(logic signed [ANG_W-1:0] v, logic neg);
    logic signed [ANG_W-1:0] n;
    logic signed [ANG_W-1:0] r;
    n = neg ? -v : v;
    r = (n + 20'sd2) >>> 2;
    if (r > TRIG_MAX) r = TRIG_MAX;
    else if (r < -TRIG_MAX) r = -TRIG_MAX;
    return q14_t'(r);
  endfunction

  function automatic q14_t q42_round(logic signed [43:0] s);
    logic signed [43:0] r;
    r = (s + Q42_HALF) >>> 28;
    if (r > Q42_MAX) r = Q42_MAX;
    else if (r < -Q42_MAX) r = -Q42_MAX;
    return q14_t'(r);
  endfunction

  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned k);
    logic [SQ_W-1:0] t;
    sqrt_t r;
    t = (SQ_W'(s.root) << (k + 1)) | (SQ_W'(1) << (2 * k));
    r = s;
    if (s.rem >= t) begin
      r.rem  = s.rem - t;
      r.root = s.root | (ROOT_W'(1) << k);
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t d, logic [NORM_W-1:0] n, int unsigned k);
    logic [DIV_REM_W-1:0] t;
    div_t r;
    t = DIV_REM_W'(n) << k;
    r = d;
    if (d.rem >= t) begin
      r.rem = d.rem - t;
      r.quo = d.quo | (DIV_STEPS'(1) << k);
    end
    return r;
  endfunction

  function automatic q14_t rate_sat(logic signed [35:0] p);
    logic signed [35:0] s;
    logic signed [19:0] r;
    s = (p + RATE_HALF) >>> 16;
    r = 20'(s);
    if (r > RATE_MAX) r = RATE_MAX;
    else if (r < RATE_MIN) r = RATE_MIN;
    return q14_t'(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_orientation_error_rate.sv =====
// ---------------------------------------------------------------------------
// quaternion_orientation_error_rate
// Desired attitude from target bearing and roll, quaternion error log map,
// per-axis gain to angular rate.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake   Payload
// item     in   start/busy  current_w/x/y/z_i, target_x/y_i, target_roll_i
// result   out  valid_o     rate_x/y/z_o, desired_w/x/y/z_o
// config   in   cfg_we_i    cfg_idx_i, cfg_wdata_i
//
// One word accepted every cycle; busy is always low.
// The result path runs through the chain of heading CORDIC, sine/cosine
// CORDIC, 29-step square root, acos CORDIC and 19-step divider, one step
// per stage.
// Reset clears the valid line and restores the gains.
// valid_o is a one-cycle strobe; the receiver cannot stall the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module quaternion_orientation_error_rate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] current_w_i,
  input  logic signed [15:0] current_x_i,
  input  logic signed [15:0] current_y_i,
  input  logic signed [15:0] current_z_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] target_roll_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        valid_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic signed [15:0] desired_w_o,
  output logic signed [15:0] desired_x_o,
  output logic signed [15:0] desired_y_o,
  output logic signed [15:0] desired_z_o
);

  import qoer_pkg::*;

  localparam int S_HDG      = CORDIC_STEPS;
  localparam int S_ROT0     = S_HDG + 1;
  localparam int S_DES      = S_ROT0 + CORDIC_STEPS + 4;
  localparam int S_DOT      = S_DES + 1;
  localparam int S_E1       = S_DES + 5;
  localparam int NORM_STEPS = NORM_W;
  localparam int ACOS_STEPS = ROOT_W;
  localparam int S_E3       = S_E1 + 2;
  localparam int S_NORM     = S_E1 + 1 + NORM_STEPS;
  localparam int S_SQ       = S_E3 + ACOS_STEPS;
  localparam int S_ANG      = S_SQ + 1 + CORDIC_STEPS;
  localparam int S_QUO      = S_ANG + 2 + DIV_STEPS;
  localparam int S_OUT      = S_QUO + 2;
  localparam int DES_LEN    = S_OUT - S_DES + 1;
  localparam int W_LEN      = S_SQ - S_E1 + 1;
  localparam int VR_LEN     = S_ANG - S_E1 + 1;
  localparam int NRM_LEN    = S_ANG - S_NORM;

  // valid line and gains
  logic [S_OUT:0]     vld_q;
  logic signed [15:0] gain_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[S_OUT-1:0], start};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= -16'sd5734;
      gain_q[1] <= -16'sd5734;
      gain_q[2] <= -16'sd5734;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_X: gain_q[0] <= cfg_wdata_i;
        CFG_GAIN_Y: gain_q[1] <= cfg_wdata_i;
        CFG_GAIN_Z: gain_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy    = 1'b0;
  assign valid_o = vld_q[S_OUT];

  // heading CORDIC
  vec_t               hdg_q   [S_HDG+1];
  logic               hzero_q [S_HDG+1];
  logic signed [15:0] tr_q    [S_HDG+1];
  quat_t              cur_q   [S_DOT+1];

  always_ff @(posedge clk_i) begin
    hdg_q[0]   <= vec_pre(VEC_W'(target_x_i) <<< 14, VEC_W'(target_y_i) <<< 14);
    hzero_q[0] <= (target_x_i == '0) && (target_y_i == '0);
    tr_q[0]    <= target_roll_i;
    cur_q[0]   <= '{current_w_i, current_x_i, current_y_i, current_z_i};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_hdg
    always_ff @(posedge clk_i) begin
      hdg_q[i+1]   <= vec_step(hdg_q[i], i);
      hzero_q[i+1] <= hzero_q[i];
      tr_q[i+1]    <= tr_q[i];
    end
  end

  for (genvar s = 0; s < S_DOT; s++) begin : g_cur
    always_ff @(posedge clk_i) begin
      cur_q[s+1] <= cur_q[s];
    end
  end

  // yaw and roll sine/cosine
  logic signed [ANG_W-1:0] heading;
  logic signed [ANG_W-1:0] yaw_ang;
  logic signed [ANG_W-1:0] roll_ang;
  rot_t                    yaw_q  [CORDIC_STEPS+1];
  rot_t                    roll_q [CORDIC_STEPS+1];

  assign heading  = hzero_q[S_HDG] ? '0 : hdg_q[S_HDG].z;
  assign yaw_ang  = (-heading) >>> 1;
  assign roll_ang = ANG_W'(tr_q[S_HDG]) <<< 2;

  always_ff @(posedge clk_i) begin
    yaw_q[0]  <= rot_pre(yaw_ang);
    roll_q[0] <= rot_pre(roll_ang);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      yaw_q[i+1]  <= rot_step(yaw_q[i], i);
      roll_q[i+1] <= rot_step(roll_q[i], i);
    end
  end

  // desired quaternion
  q14_t               yc_q, ys_q, rc_q, rs_q;
  logic signed [31:0] pcc_q, pss_q, psc_q, pcs_q;
  logic signed [43:0] m_q [8];
  quat_t              des_q [DES_LEN];

  always_ff @(posedge clk_i) begin
    yc_q  <= trig_q14(yaw_q[CORDIC_STEPS].x, yaw_q[CORDIC_STEPS].neg);
    ys_q  <= trig_q14(yaw_q[CORDIC_STEPS].y, yaw_q[CORDIC_STEPS].neg);
    rc_q  <= trig_q14(roll_q[CORDIC_STEPS].x, roll_q[CORDIC_STEPS].neg);
    rs_q  <= trig_q14(roll_q[CORDIC_STEPS].y, roll_q[CORDIC_STEPS].neg);
    pcc_q <= 32'(yc_q) * 32'(rc_q);
    pss_q <= 32'(ys_q) * 32'(rs_q);
    psc_q <= 32'(ys_q) * 32'(rc_q);
    pcs_q <= 32'(yc_q) * 32'(rs_q);
    m_q[0] <= 44'(pcc_q) * 44'(PITCH_COS);
    m_q[1] <= 44'(pss_q) * 44'(PITCH_SIN);
    m_q[2] <= 44'(psc_q) * 44'(PITCH_COS);
    m_q[3] <= 44'(pcs_q) * 44'(PITCH_SIN);
    m_q[4] <= 44'(pcc_q) * 44'(PITCH_SIN);
    m_q[5] <= 44'(pss_q) * 44'(PITCH_COS);
    m_q[6] <= 44'(pcs_q) * 44'(PITCH_COS);
    m_q[7] <= 44'(psc_q) * 44'(PITCH_SIN);
    des_q[0] <= '{q42_round(m_q[0] + m_q[1]), q42_round(m_q[2] + m_q[3]),
                  q42_round(m_q[4] - m_q[5]), q42_round(m_q[6] - m_q[7])};
  end

  for (genvar s = 0; s < DES_LEN - 1; s++) begin : g_des
    always_ff @(posedge clk_i) begin
      des_q[s+1] <= des_q[s];
    end
  end

  // hemisphere flip and error quaternion
  logic signed [31:0] dp_q [4];
  logic signed [33:0] dot_c;
  logic signed [16:0] fq_q [4];
  logic signed [33:0] ep_q [4][4];
  logic signed [33:0] ew_q;
  logic signed [33:0] ev_q [3];

  assign dot_c = 34'(dp_q[0]) + 34'(dp_q[1]) + 34'(dp_q[2]) + 34'(dp_q[3]);

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) begin
      dp_q[a] <= 32'(des_q[0][a]) * 32'(cur_q[S_DOT-1][a]);
      fq_q[a] <= dot_c[33] ? -17'(cur_q[S_DOT][a]) : 17'(cur_q[S_DOT][a]);
      for (int b = 0; b < 4; b++) begin
        ep_q[a][b] <= 34'(fq_q[a]) * 34'(des_q[2][b]);
      end
    end
    ew_q    <= ep_q[0][0] + ep_q[1][1] + ep_q[2][2] + ep_q[3][3];
    ev_q[0] <= ep_q[1][0] - ep_q[0][1] - ep_q[2][3] + ep_q[3][2];
    ev_q[1] <= ep_q[2][0] - ep_q[0][2] - ep_q[3][1] + ep_q[1][3];
    ev_q[2] <= ep_q[3][0] - ep_q[0][3] - ep_q[1][2] + ep_q[2][1];
  end

  // rotation angle and axis norm
  logic signed [25:0] vr_c [3];
  logic signed [33:0] ewc_c;
  logic signed [29:0] w_q  [W_LEN];
  logic signed [25:0] vr_q [VR_LEN][3];
  logic [47:0]        vsq_q [3];
  logic [56:0]        ww_q;
  sqrt_t              norm_q [NORM_STEPS+1];
  sqrt_t              aq_q   [ACOS_STEPS+1];
  logic [NORM_W-1:0]  nrm_q  [NRM_LEN];
  vec_t               ang_q  [CORDIC_STEPS+1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vr_c[k] = 26'(ev_q[k] >>> 8);
    end
    if (ew_q > ONE_Q28) ewc_c = ONE_Q28;
    else if (ew_q < -ONE_Q28) ewc_c = -ONE_Q28;
    else ewc_c = ew_q;
  end

  always_ff @(posedge clk_i) begin
    w_q[0]  <= 30'(ewc_c);
    vr_q[0] <= vr_c;
    for (int k = 0; k < 3; k++) begin
      vsq_q[k] <= 48'(52'(vr_c[k]) * 52'(vr_c[k]));
    end
    ww_q           <= 57'(60'(w_q[0]) * 60'(w_q[0]));
    norm_q[0].rem  <= SQ_W'(vsq_q[0]) + SQ_W'(vsq_q[1]) + SQ_W'(vsq_q[2]);
    norm_q[0].root <= '0;
    aq_q[0].rem    <= ONE_Q56 - SQ_W'(ww_q);
    aq_q[0].root   <= '0;
    nrm_q[0]       <= norm_q[NORM_STEPS].root[NORM_W-1:0];
    ang_q[0]       <= vec_pre(VEC_W'(w_q[W_LEN-1]), signed'(VEC_W'(aq_q[ACOS_STEPS].root)));
  end

  for (genvar s = 0; s < W_LEN - 1; s++) begin : g_wl
    always_ff @(posedge clk_i) begin
      w_q[s+1] <= w_q[s];
    end
  end

  for (genvar s = 0; s < VR_LEN - 1; s++) begin : g_vrl
    always_ff @(posedge clk_i) begin
      vr_q[s+1] <= vr_q[s];
    end
  end

  for (genvar s = 0; s < NRM_LEN - 1; s++) begin : g_nrl
    always_ff @(posedge clk_i) begin
      nrm_q[s+1] <= nrm_q[s];
    end
  end

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_nsq
    always_ff @(posedge clk_i) begin
      norm_q[j+1] <= sqrt_step(norm_q[j], NORM_STEPS - 1 - j);
    end
  end

  for (genvar j = 0; j < ACOS_STEPS; j++) begin : g_asq
    always_ff @(posedge clk_i) begin
      aq_q[j+1] <= sqrt_step(aq_q[j], ACOS_STEPS - 1 - j);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_acos
    always_ff @(posedge clk_i) begin
      ang_q[i+1] <= vec_step(ang_q[i], i);
    end
  end

  // log map division and gain
  logic signed [45:0] prod_q [3];
  logic [NORM_W-1:0]  pn_q;
  div_t               div_q  [DIV_STEPS+1][3];
  logic [NORM_W-1:0]  dnrm_q [DIV_STEPS+1];
  logic               nz_q;
  logic signed [19:0] lg_c [3];
  logic signed [35:0] gp_q [3];
  q14_t               rate_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lg_c[k] = signed'(20'(div_q[DIV_STEPS][k].quo));
      if (div_q[DIV_STEPS][k].neg) lg_c[k] = -lg_c[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k]       <= 46'(ang_q[CORDIC_STEPS].z) * 46'(vr_q[VR_LEN-1][k]);
      div_q[0][k].neg <= prod_q[k][45];
      div_q[0][k].rem <= DIV_REM_W'(prod_q[k][45] ? -prod_q[k] : prod_q[k]);
      div_q[0][k].quo <= '0;
      gp_q[k]         <= 36'(gain_q[k]) * 36'(lg_c[k]);
      rate_q[k]       <= nz_q ? rate_sat(gp_q[k]) : '0;
    end
    pn_q      <= nrm_q[NRM_LEN-1];
    dnrm_q[0] <= pn_q;
    nz_q      <= (dnrm_q[DIV_STEPS] != '0);
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        div_q[j+1][k] <= div_step(div_q[j][k], dnrm_q[j], DIV_STEPS - 1 - j);
      end
      dnrm_q[j+1] <= dnrm_q[j];
    end
  end

  assign rate_x_o    = rate_q[0];
  assign rate_y_o    = rate_q[1];
  assign rate_z_o    = rate_q[2];
  assign desired_w_o = des_q[DES_LEN-1][0];
  assign desired_x_o = des_q[DES_LEN-1][1];
  assign desired_y_o = des_q[DES_LEN-1][2];
  assign desired_z_o = des_q[DES_LEN-1][3];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, S_OUT + 1))
    else $error("result strobe without a matching accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (desired_w_o <= 16'sd16384) && (desired_w_o >= -16'sd16384) &&
                (desired_y_o <= 16'sd16384) && (desired_y_o >= -16'sd16384))
    else $error("desired quaternion out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_QUO] && (dnrm_q[DIV_STEPS] != '0) |->
      (div_q[DIV_STEPS][0].rem < DIV_REM_W'(dnrm_q[DIV_STEPS])) &&
      (div_q[DIV_STEPS][1].rem < DIV_REM_W'(dnrm_q[DIV_STEPS])) &&
      (div_q[DIV_STEPS][2].rem < DIV_REM_W'(dnrm_q[DIV_STEPS])))
    else $error("log map quotient overflowed its bit range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_SQ] |-> (aq_q[ACOS_STEPS].root <= (ROOT_W'(1) << 28)))
    else $error("acos square root above one");

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_orientation_error_rate_tb.sv =====
// ---------------------------------------------------------------------------
// quaternion_orientation_error_rate_tb
// Drives orientation/target words with bursty gaps and gain changes at idle,
// and predicts rates and desired quaternion in fixed point for each word.
// ---------------------------------------------------------------------------
`default_nettype none

module quaternion_orientation_error_rate_tb;
  import qoer_pkg::*;

  localparam int LATENCY = 113;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] rx, ry, rz, dw, dx, dy, dz;
  } attitude_rate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] cur_w = '0, cur_x = '0, cur_y = '0, cur_z = '0;
  logic signed [15:0] tgt_x = '0, tgt_y = '0, tgt_roll = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;
  logic valid_o;
  logic signed [15:0] rate_x_o, rate_y_o, rate_z_o;
  logic signed [15:0] desired_w_o, desired_x_o, desired_y_o, desired_z_o;

  longint gain [3];
  attitude_rate_t pending_rates [$];
  int n_fail = 0;
  int n_words = 0;
  int n_results = 0;
  longint n_cycles = 0;

  always #2 clk_i = ~clk_i;

  quaternion_orientation_error_rate dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .current_w_i(cur_w), .current_x_i(cur_x), .current_y_i(cur_y),
    .current_z_i(cur_z), .target_x_i(tgt_x), .target_y_i(tgt_y),
    .target_roll_i(tgt_roll), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .valid_o(valid_o), .rate_x_o(rate_x_o),
    .rate_y_o(rate_y_o), .rate_z_o(rate_z_o), .desired_w_o(desired_w_o),
    .desired_x_o(desired_x_o), .desired_y_o(desired_y_o),
    .desired_z_o(desired_z_o)
  );

  function automatic longint floor_shr(longint v, int s);
    return (v >= 0) ? (v >> s) : (-1 - ((-1 - v) >> s));
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint arc_of(longint y, longint x);
    longint z, ddx, ddy;
    longint tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      ddx = floor_shr(y, i);
      ddy = floor_shr(x, i);
      if (y >= 0) begin
        x += ddx; y -= ddy; z += tab[i];
      end else begin
        x -= ddx; y += ddy; z -= tab[i];
      end
    end
    return z;
  endfunction

  task automatic cos_sin(input longint a, output longint c, output longint s);
    longint x, y, ddx, ddy;
    bit flip;
    longint tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
    x = 39797;
    y = 0;
    flip = 0;
    if (a > 102944) begin
      a -= 205887; flip = 1;
    end else if (a < -102944) begin
      a += 205887; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      ddx = floor_shr(y, i);
      ddy = floor_shr(x, i);
      if (a >= 0) begin
        x -= ddx; y += ddy; a -= tab[i];
      end else begin
        x += ddx; y -= ddy; a += tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = limit(floor_shr(x + 2, 2), -16384, 16384);
    s = limit(floor_shr(y + 2, 2), -16384, 16384);
  endtask

  function automatic longint round_q42(longint v);
    return limit(floor_shr(v + (64'sd1 <<< 27), 28), -16384, 16384);
  endfunction

  task automatic predict_rates(input longint s1, ax, ay, az, tx, ty, tr,
                               output attitude_rate_t res);
    longint yc, ys, rc, rs, dw, dx, dy, dz, ew, w, ang, nrm, lg, heading;
    longint ev [3];
    longint vr [3];
    longint rt [3];
    heading = arc_of(ty * 16384, tx * 16384);
    cos_sin(floor_shr(-heading, 1), yc, ys);
    cos_sin(tr * 4, rc, rs);
    dw = round_q42(11590 * yc * rc + 11581 * ys * rs);
    dx = round_q42(11590 * ys * rc + 11581 * yc * rs);
    dy = round_q42(11581 * yc * rc - 11590 * ys * rs);
    dz = round_q42(11590 * yc * rs - 11581 * ys * rc);
    if (dw * s1 + dx * ax + dy * ay + dz * az < 0) begin
      s1 = -s1; ax = -ax; ay = -ay; az = -az;
    end
    ew = s1 * dw + ax * dx + ay * dy + az * dz;
    ev[0] = -s1 * dx + dw * ax - (ay * dz - az * dy);
    ev[1] = -s1 * dy + dw * ay - (az * dx - ax * dz);
    ev[2] = -s1 * dz + dw * az - (ax * dy - ay * dx);
    w = limit(ew, -268435456, 268435456);
    ang = arc_of(longint'(int_root(longint'(64'sd1 <<< 56) - w * w)), w);
    for (int k = 0; k < 3; k++) vr[k] = floor_shr(ev[k], 8);
    nrm = longint'(int_root(vr[0] * vr[0] + vr[1] * vr[1] + vr[2] * vr[2]));
    for (int k = 0; k < 3; k++) begin
      rt[k] = 0;
      if (nrm != 0) begin
        lg = (ang * vr[k]) / nrm;
        rt[k] = limit(floor_shr(gain[k] * lg + 32768, 16), -32768, 32767);
      end
    end
    res.rx = 16'(rt[0]); res.ry = 16'(rt[1]); res.rz = 16'(rt[2]);
    res.dw = 16'(dw); res.dx = 16'(dx); res.dy = 16'(dy); res.dz = 16'(dz);
  endtask

  task automatic send_word(input logic signed [15:0] w, x, y, z, tx, ty, tr);
    attitude_rate_t exp_r;
    cur_w <= w; cur_x <= x; cur_y <= y; cur_z <= z;
    tgt_x <= tx; tgt_y <= ty; tgt_roll <= tr;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_rates(w, x, y, z, tx, ty, tr, exp_r);
    pending_rates.push_back(exp_r);
    n_words++;
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gain(input cfg_idx_e idx, input logic signed [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    gain[idx] = v;
    @(posedge clk_i);
  endtask

  task automatic set_gains(input logic signed [15:0] gx, gy, gz);
    write_gain(CFG_GAIN_X, gx);
    write_gain(CFG_GAIN_Y, gy);
    write_gain(CFG_GAIN_Z, gz);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_q14();
    return $urandom_range(0, 7) == 0 ? 16'($urandom()) :
           16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] rand_roll();
    return $urandom_range(0, 7) == 0 ? 16'($urandom()) :
           16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  task automatic send_random(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
      burst--;
      send_word(rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                16'($urandom()), 16'($urandom()), rand_roll());
    end
  endtask

  task automatic test_directed();
    send_word(16384, 0, 0, 0, 0, 0, 0);
    send_word(16384, 0, 0, 0, 4096, 0, 0);
    send_word(11590, 0, 11581, 0, 4096, 0, 0);
    send_word(-11590, 0, -11581, 0, 4096, 0, 0);
    send_word(-16384, -16384, -16384, -16384, 32767, 32767, 25736);
    send_word(16384, 16384, 16384, 16384, -32768, -32768, -25736);
    send_word(0, 0, 0, 0, -32768, 0, 0);
    send_word(-32768, -32768, -32768, -32768, 0, -32768, -32768);
    send_word(32767, 32767, 32767, 32767, -4096, 1, 32767);
    send_word(16384, 0, 0, 0, 0, 4096, 12868);
    send_word(0, 16384, 0, 0, -4096, -1, -12868);
    send_word(0, 0, 0, 16384, 1, -4096, 1);
    send_word(8192, 8192, 8192, 8192, 4096, 4096, 0);
    drain_pipe();
  endtask

  task automatic test_gain_sweep();
    set_gains(16'sh7fff, 16'sh8000, 16'sh0000);
    send_random(150);
    drain_pipe();
    set_gains(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_random(150);
    drain_pipe();
    set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()));
    send_random(200);
    drain_pipe();
  endtask

  task automatic test_random_stream();
    set_gains(-16'sd5734, -16'sd5734, -16'sd5734);
    send_random(600);
    drain_pipe();
  endtask

  always @(posedge clk_i) begin
    attitude_rate_t e;
    if (valid_o) begin
      if (pending_rates.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        n_fail++;
      end else begin
        e = pending_rates.pop_front();
        n_results++;
        if ({rate_x_o, rate_y_o, rate_z_o, desired_w_o, desired_x_o, desired_y_o,
             desired_z_o} !== {e.rx, e.ry, e.rz, e.dw, e.dx, e.dy, e.dz}) begin
          n_fail++;
          $display("%0t: expected rate %0d %0d %0d q %0d %0d %0d %0d", $time,
                   e.rx, e.ry, e.rz, e.dw, e.dx, e.dy, e.dz);
          $display("%0t: actual   rate %0d %0d %0d q %0d %0d %0d %0d", $time,
                   rate_x_o, rate_y_o, rate_z_o, desired_w_o, desired_x_o,
                   desired_y_o, desired_z_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    gain[0] = -5734; gain[1] = -5734; gain[2] = -5734;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_gain_sweep();
    test_random_stream();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (pending_rates.size() != 0) begin
      $display("%0d results never arrived", pending_rates.size());
      n_fail++;
    end
    $display("sent %0d words, checked %0d results over gain settings incl. extremes",
             n_words, n_results);
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
